// ===== sv/dhb_pkg.sv =====
// Shared types and constants for the dual H-bridge PWM drive unit.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package dhb_pkg;

    localparam int CNT_W  = 16;  // timer count width
    localparam int DUTY_W = 17;  // signed duty / command width

    typedef enum logic [2:0] {
        OP_SET_PWM = 3'd0,
        OP_COAST   = 3'd1,
        OP_BRAKE   = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4,
        OP_ESTOP   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        REG_TIMER_PERIOD  = 3'd0,
        REG_LEFT_LIMIT    = 3'd1,
        REG_RIGHT_LIMIT   = 3'd2,
        REG_LEFT_MIN_EFF  = 3'd3,
        REG_RIGHT_MIN_EFF = 3'd4,
        REG_LEFT_REVERSE  = 3'd5,
        REG_RIGHT_REVERSE = 3'd6,
        REG_MASTER_ENABLE = 3'd7
    } reg_idx_t;

    // bridge pin pairs, bit 0 = in1, bit 1 = in2
    localparam logic [1:0] PINS_OFF   = 2'b00;
    localparam logic [1:0] PINS_FWD   = 2'b01;
    localparam logic [1:0] PINS_REV   = 2'b10;
    localparam logic [1:0] PINS_BRAKE = 2'b11;

    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [CNT_W-1:0] LIMIT_RST  = 16'd1000;

    // result beat layout
    localparam int OUT_W = 72;

endpackage

`default_nettype wire

// ===== sv/dual_h_bridge_pwm_drive_unit.sv =====
// An input beat passes the input register and then the result register to become its result beat.
// Throughput: one command per cycle unless the result stream stalls; the drive state updates in the
// single compute pass between the two registers, so each command sees the state left by the one before.
// Reset (aresetn low, synchronous): config registers to defaults, driver disabled,
// pins low, compares at 1000, applied duty zero, both channels empty. No clearing pass.
// Depends on dhb_pkg.
`default_nettype none

module dual_h_bridge_pwm_drive_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] command
    input  wire logic [7:0]  s_tuser,   // [2:0] opcode, [3] channel
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [0] left_in1, [1] left_in2, [2] right_in1,
                                        // [3] right_in2, [4] standby_pin,
                                        // [20:5] left_compare, [36:21] right_compare,
                                        // [53:37] left_applied, [70:54] right_applied,
                                        // [71] driver_on
);
    import dhb_pkg::*;

    // configuration
    logic [CNT_W-1:0] period_reg;
    logic [CNT_W-1:0] lim_reg [2];
    logic [CNT_W-1:0] min_eff_reg [2];
    logic             rev_reg [2];
    logic             master_en_reg;

    // drive state
    logic                     en_reg, en_next;
    logic                     stby_reg, stby_next;
    logic signed [DUTY_W-1:0] duty_reg [2];
    logic signed [DUTY_W-1:0] duty_next [2];
    logic [CNT_W-1:0]         cmp_reg [2];
    logic [CNT_W-1:0]         cmp_next [2];
    logic [1:0]               pins_reg [2];
    logic [1:0]               pins_next [2];

    // input stage
    logic                     in_valid_reg;
    op_t                      in_op_reg;
    logic                     in_ch_reg;
    logic signed [DUTY_W-1:0] in_cmd_reg;

    // result stage
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic adv;
    logic s_hs;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_hs     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= PERIOD_RST;
            lim_reg[0]     <= LIMIT_RST;
            lim_reg[1]     <= LIMIT_RST;
            min_eff_reg[0] <= '0;
            min_eff_reg[1] <= '0;
            rev_reg[0]     <= 1'b0;
            rev_reg[1]     <= 1'b0;
            master_en_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_TIMER_PERIOD:  period_reg     <= cfg_wdata;
                REG_LEFT_LIMIT:    lim_reg[0]     <= cfg_wdata;
                REG_RIGHT_LIMIT:   lim_reg[1]     <= cfg_wdata;
                REG_LEFT_MIN_EFF:  min_eff_reg[0] <= cfg_wdata;
                REG_RIGHT_MIN_EFF: min_eff_reg[1] <= cfg_wdata;
                REG_LEFT_REVERSE:  rev_reg[0]     <= cfg_wdata[0];
                REG_RIGHT_REVERSE: rev_reg[1]     <= cfg_wdata[0];
                REG_MASTER_ENABLE: master_en_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_hs) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            in_op_reg  <= op_t'(s_tuser[2:0]);
            in_ch_reg  <= s_tuser[3];
            in_cmd_reg <= signed'(s_tdata[DUTY_W-1:0]);
        end
    end

    // compute pass
    logic             cmd_neg;
    logic [DUTY_W-1:0] cmd_abs;
    logic [CNT_W-1:0] lim_cap [2];
    logic [CNT_W-1:0] mag_clip [2];
    logic [CNT_W-1:0] mag_raise [2];
    logic [CNT_W-1:0] mag [2];
    logic             fwd [2];
    logic             sel [2];
    logic             stop_all;
    logic             stop_pins;

    always_comb begin
        cmd_neg = in_cmd_reg[DUTY_W-1];
        // -65536 gives 0x10000, still correct as unsigned magnitude
        cmd_abs = cmd_neg ? (DUTY_W'(0) - unsigned'(in_cmd_reg)) : unsigned'(in_cmd_reg);

        stop_all  = 1'b0;
        stop_pins = 1'b0;
        en_next   = en_reg;
        stby_next = stby_reg;
        case (in_op_reg)
            OP_SET_PWM: begin
                if (!master_en_reg) begin
                    stop_all  = 1'b1;
                    stop_pins = 1'b1;
                end
            end
            OP_ENABLE: begin
                if (master_en_reg) begin
                    en_next   = 1'b1;
                    stby_next = 1'b1;
                end else begin
                    stop_all  = 1'b1;
                    stop_pins = 1'b1;
                end
            end
            OP_DISABLE: stop_all = 1'b1;
            OP_ESTOP: begin
                stop_all  = 1'b1;
                stop_pins = 1'b1;
            end
            default: ;
        endcase
        if (stop_all) begin
            en_next   = 1'b0;
            stby_next = 1'b0;
        end

        for (int c = 0; c < 2; c++) begin
            sel[c]      = (in_ch_reg == 1'(c));
            lim_cap[c]  = (lim_reg[c] > period_reg) ? period_reg : lim_reg[c];
            mag_clip[c] = (cmd_abs > {1'b0, lim_cap[c]}) ? lim_cap[c] : cmd_abs[CNT_W-1:0];
            mag_raise[c] = ((mag_clip[c] != '0) && (mag_clip[c] < min_eff_reg[c])) ?
                           min_eff_reg[c] : mag_clip[c];
            mag[c]      = (mag_raise[c] > period_reg) ? period_reg : mag_raise[c];
            fwd[c]      = !cmd_neg ^ rev_reg[c];

            duty_next[c] = duty_reg[c];
            cmp_next[c]  = cmp_reg[c];
            pins_next[c] = pins_reg[c];

            if (stop_all) begin
                duty_next[c] = '0;
                cmp_next[c]  = period_reg;
                if (stop_pins) begin
                    pins_next[c] = PINS_OFF;
                end
            end else if (sel[c]) begin
                case (in_op_reg)
                    OP_SET_PWM: begin
                        if (!en_reg || mag[c] == '0) begin
                            duty_next[c] = '0;
                            cmp_next[c]  = period_reg;
                            pins_next[c] = PINS_OFF;
                        end else begin
                            pins_next[c] = fwd[c] ? PINS_FWD : PINS_REV;
                            cmp_next[c]  = period_reg - mag[c];
                            duty_next[c] = cmd_neg ? -signed'({1'b0, mag[c]})
                                                   :  signed'({1'b0, mag[c]});
                        end
                    end
                    OP_COAST: begin
                        duty_next[c] = '0;
                        cmp_next[c]  = period_reg;
                        pins_next[c] = PINS_OFF;
                    end
                    OP_BRAKE: begin
                        duty_next[c] = '0;
                        cmp_next[c]  = period_reg;
                        if (en_reg) begin
                            pins_next[c] = PINS_BRAKE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        out_data_next = {en_next,
                         unsigned'(duty_next[1]), unsigned'(duty_next[0]),
                         cmp_next[1], cmp_next[0],
                         stby_next,
                         pins_next[1][1], pins_next[1][0],
                         pins_next[0][1], pins_next[0][0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= 1'b0;
            stby_reg    <= 1'b0;
            duty_reg[0] <= '0;
            duty_reg[1] <= '0;
            cmp_reg[0]  <= PERIOD_RST;
            cmp_reg[1]  <= PERIOD_RST;
            pins_reg[0] <= PINS_OFF;
            pins_reg[1] <= PINS_OFF;
        end else if (adv) begin
            en_reg      <= en_next;
            stby_reg    <= stby_next;
            duty_reg[0] <= duty_next[0];
            duty_reg[1] <= duty_next[1];
            cmp_reg[0]  <= cmp_next[0];
            cmp_reg[1]  <= cmp_next[1];
            pins_reg[0] <= pins_next[0];
            pins_reg[1] <= pins_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dhb_checker.sv =====
// Port-level checks for dual_h_bridge_pwm_drive_unit, attached by bind below.
// Depends on dhb_pkg and the top level's port list.
`default_nettype none

module dhb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    import dhb_pkg::*;

    logic left_drive, right_drive;
    assign left_drive  = (m_tdata[53:37] != '0);
    assign right_drive = (m_tdata[70:54] != '0);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // standby pin follows the enabled flag
    a_standby: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4] == m_tdata[71]))
        else $error("standby pin and driver_on disagree");

    // nonzero duty only with exactly one bridge pin high, and only while enabled
    a_drive_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (left_drive || right_drive) |->
            m_tdata[71] &&
            (!left_drive || (m_tdata[0] ^ m_tdata[1])) &&
            (!right_drive || (m_tdata[2] ^ m_tdata[3])))
        else $error("duty applied without a single direction pin or while disabled");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_h_bridge_pwm_drive_unit dhb_checker u_dhb_checker (.*);

`default_nettype wire

// ===== verif/dual_h_bridge_pwm_drive_unit_test.sv =====
// Self-checking testbench for dual_h_bridge_pwm_drive_unit: a directed command table, then
// randomized command streams under several register settings, each beat checked against a
// behavioral model of the drive state or a literal expected result. Depends on dhb_pkg and the unit's RTL.
`default_nettype none

module dual_h_bridge_pwm_drive_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dhb_pkg::*;

    localparam logic [2:0] OP_RSVD_6 = 3'd6;  // unused opcodes: state is reported unchanged
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    localparam int SETTLE_CYCLES = 4;         // two-stage pipe plus margin
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 150;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 195;

    // result beat fields, lowest bit last
    typedef struct packed {
        logic        driver_on;
        logic [16:0] right_applied;
        logic [16:0] left_applied;
        logic [15:0] right_compare;
        logic [15:0] left_compare;
        logic        standby_pin;
        logic        right_in2;
        logic        right_in1;
        logic        left_in2;
        logic        left_in1;
    } drive_res_t;

    typedef struct packed {
        logic        is_wr;   // register write instead of a command beat
        reg_idx_t    idx;
        logic [15:0] wval;
        logic [2:0]  op;
        logic        ch;
        logic [16:0] cmd;
        logic        typed;   // use the literal result below instead of the model
        drive_res_t  want;
    } dir_row_t;

    localparam drive_res_t RES_STOPPED =
        '{1'b0, 17'd0, 17'd0, 16'd1000, 16'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam drive_res_t RES_ENABLED =
        '{1'b1, 17'd0, 17'd0, 16'd1000, 16'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam drive_res_t RES_LEFT_FULL =
        '{1'b1, 17'd0, 17'd1000, 16'd1000, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam drive_res_t RES_BOTH_FULL =
        '{1'b1, -17'sd1000, 17'd1000, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    localparam int NUM_ROWS = 36;
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_COAST, 1'b0, 17'd0, 1'b1, RES_STOPPED},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'd500, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_BRAKE, 1'b1, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_ENABLE, 1'b0, 17'd0, 1'b1, RES_ENABLED},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'h0FFFF, 1'b1, RES_LEFT_FULL},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b1, 17'h10000, 1'b1, RES_BOTH_FULL},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'h1FFFF, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b1, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_BRAKE, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_RSVD_6, 1'b1, 17'h0AAAA, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_RSVD_7, 1'b0, 17'h15555, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_DISABLE, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_BRAKE, 1'b1, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_ESTOP, 1'b1, 17'd0, 1'b1, RES_STOPPED},
        '{1'b1, REG_LEFT_MIN_EFF, 16'd300, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b1, REG_RIGHT_LIMIT, 16'd200, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b1, REG_LEFT_REVERSE, 16'd1, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b1, REG_RIGHT_REVERSE, 16'hFFFF, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_ENABLE, 1'b1, 17'd0, 1'b0, '0},
        // tiny magnitude raised to the minimum
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'd1, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b1, 17'h0FFFF, 1'b0, '0},
        // minimum above the period gets capped
        '{1'b1, REG_RIGHT_MIN_EFF, 16'd2000, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b1, 17'd5, 1'b0, '0},
        // period change leaves stored compares alone
        '{1'b1, REG_TIMER_PERIOD, 16'd500, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_RSVD_6, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'd700, 1'b0, '0},
        '{1'b1, REG_TIMER_PERIOD, 16'd0, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'd100, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_BRAKE, 1'b1, 17'd0, 1'b0, '0},
        '{1'b1, REG_TIMER_PERIOD, 16'hFFFF, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b1, REG_LEFT_LIMIT, 16'hFFFF, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b0, 17'h10001, 1'b0, '0},
        // master enable off: set and enable turn into e-stop
        '{1'b1, REG_MASTER_ENABLE, 16'hFFFE, OP_COAST, 1'b0, 17'd0, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_SET_PWM, 1'b1, 17'd10, 1'b0, '0},
        '{1'b0, REG_TIMER_PERIOD, 16'd0, OP_ENABLE, 1'b0, 17'd0, 1'b0, '0},
        '{1'b1, REG_MASTER_ENABLE, 16'd1, OP_COAST, 1'b0, 17'd0, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [7:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    dual_h_bridge_pwm_drive_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // drive model: registers and state
    logic [15:0] pwm_period;
    logic [15:0] ch_limit [2];
    logic [15:0] ch_min [2];
    logic        ch_rev [2];
    logic        master_on;
    logic        drv_on;
    logic        stby;
    logic [16:0] duty [2];
    logic [15:0] cmp [2];
    logic [1:0]  pins [2];

    drive_res_t pending_results [$];
    int         errors;
    bit         idle_on;
    bit         ready_hold_req;
    int         stall_cycles;

    function automatic void halt_drive(bit clear_pins);
        drv_on = 1'b0;
        stby   = 1'b0;
        for (int c = 0; c < 2; c++) begin
            cmp[c]  = pwm_period;
            duty[c] = '0;
            if (clear_pins) pins[c] = PINS_OFF;
        end
    endfunction

    function automatic void coast_channel(logic ch);
        cmp[ch]  = pwm_period;
        pins[ch] = PINS_OFF;
        duty[ch] = '0;
    endfunction

    function automatic void restore_defaults();
        pwm_period  = PERIOD_RST;
        ch_limit[0] = LIMIT_RST;
        ch_limit[1] = LIMIT_RST;
        ch_min[0]   = '0;
        ch_min[1]   = '0;
        ch_rev[0]   = 1'b0;
        ch_rev[1]   = 1'b0;
        master_on   = 1'b1;
        halt_drive(1'b1);
    endfunction

    task automatic predict_drive(input logic [2:0] op, input logic ch,
                                 input logic signed [16:0] cmd, output drive_res_t r);
        int lim;
        int mag;
        bit neg;
        bit fwd;
        case (op)
            OP_SET_PWM: begin
                if (!master_on) begin
                    halt_drive(1'b1);
                end else if (!drv_on) begin
                    coast_channel(ch);
                end else begin
                    lim = ch_limit[ch];
                    if (lim > pwm_period) lim = pwm_period;
                    neg = cmd[16];
                    mag = cmd;
                    if (neg) mag = -mag;
                    if (mag > lim) mag = lim;
                    if (mag > 0 && mag < ch_min[ch]) mag = ch_min[ch];
                    if (mag > pwm_period) mag = pwm_period;
                    if (mag == 0) begin
                        coast_channel(ch);
                    end else begin
                        fwd = !neg;
                        if (ch_rev[ch]) fwd = !fwd;
                        pins[ch] = fwd ? PINS_FWD : PINS_REV;
                        cmp[ch]  = 16'(pwm_period - mag);
                        duty[ch] = 17'(neg ? -mag : mag);
                    end
                end
            end
            OP_COAST: coast_channel(ch);
            OP_BRAKE: begin
                cmp[ch] = pwm_period;
                if (drv_on) pins[ch] = PINS_BRAKE;
                duty[ch] = '0;
            end
            OP_ENABLE: begin
                if (master_on) begin
                    drv_on = 1'b1;
                    stby   = 1'b1;
                end else begin
                    halt_drive(1'b1);
                end
            end
            OP_DISABLE: halt_drive(1'b0);
            OP_ESTOP:   halt_drive(1'b1);
            default: ;
        endcase
        r.left_in1      = pins[0][0];
        r.left_in2      = pins[0][1];
        r.right_in1     = pins[1][0];
        r.right_in2     = pins[1][1];
        r.standby_pin   = stby;
        r.left_compare  = cmp[0];
        r.right_compare = cmp[1];
        r.left_applied  = duty[0];
        r.right_applied = duty[1];
        r.driver_on     = drv_on;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TIMER_PERIOD:  pwm_period  = v;
            REG_LEFT_LIMIT:    ch_limit[0] = v;
            REG_RIGHT_LIMIT:   ch_limit[1] = v;
            REG_LEFT_MIN_EFF:  ch_min[0]   = v;
            REG_RIGHT_MIN_EFF: ch_min[1]   = v;
            REG_LEFT_REVERSE:  ch_rev[0]   = v[0];
            REG_RIGHT_REVERSE: ch_rev[1]   = v[0];
            REG_MASTER_ENABLE: master_on   = v[0];
            default: ;
        endcase
    endtask

    task automatic send_cmd(input logic [2:0] op, input logic ch, input logic [16:0] cmd,
                            input bit typed, input drive_res_t want);
        drive_res_t r;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cmd};
        s_tuser  <= {4'd0, ch, op};
        do @(posedge aclk); while (!s_tready);
        predict_drive(op, ch, cmd, r);
        pending_results.push_back(typed ? want : r);
    endtask

    // stop sending and let every outstanding beat come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int clip16(int v);
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic setup_phase(input int ph);
        int per, ll, rl, lm, rm, lr, rr, me;
        per = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(20, 2000);
        ll  = $urandom_range(0, clip16(per + per / 4));
        rl  = $urandom_range(0, clip16(per + per / 4));
        lm  = $urandom_range(0, per / 3);
        rm  = $urandom_range(0, per / 3);
        lr  = $urandom;
        rr  = $urandom;
        me  = $urandom | 1;
        case (ph)
            0: begin
                per = 1000; ll = 1000; rl = 1000;
                lm = 0; rm = 0; lr = 0; rr = 0;
            end
            1: begin
                per = 65535; ll = 65535; rl = 65535; lm = 0; rm = 0;
            end
            2: begin
                per = 1; ll = 1; rl = 65535; lm = 0; rm = 65535;
            end
            3: per = 0;
            4: begin
                lm = 65535; rm = 65535;
            end
            5: begin
                ll = 0; rl = 0;
            end
            6: me = $urandom & 32'hFFFE;
            default: ;
        endcase
        write_reg(REG_TIMER_PERIOD, per[15:0]);
        write_reg(REG_LEFT_LIMIT, ll[15:0]);
        write_reg(REG_RIGHT_LIMIT, rl[15:0]);
        write_reg(REG_LEFT_MIN_EFF, lm[15:0]);
        write_reg(REG_RIGHT_MIN_EFF, rm[15:0]);
        write_reg(REG_LEFT_REVERSE, lr[15:0]);
        write_reg(REG_RIGHT_REVERSE, rr[15:0]);
        write_reg(REG_MASTER_ENABLE, me[15:0]);
    endtask

    task automatic rand_cmd(output logic [2:0] op, output logic ch, output logic [16:0] cmd);
        int sel;
        int mag;
        sel = $urandom_range(0, 99);
        if (sel < 55)      op = OP_SET_PWM;
        else if (sel < 67) op = OP_ENABLE;
        else if (sel < 74) op = OP_COAST;
        else if (sel < 81) op = OP_BRAKE;
        else if (sel < 86) op = OP_DISABLE;
        else if (sel < 90) op = OP_ESTOP;
        else               op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
        ch = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       mag = -1;
            1:       mag = $urandom_range(0, 20);
            default: mag = $urandom_range(0, clip16(pwm_period + pwm_period / 4 + 64));
        endcase
        if (mag < 0) cmd = 17'($urandom);
        else         cmd = 17'($urandom_range(0, 1) ? -mag : mag);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        drive_res_t got;
        drive_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("left_in1", want.left_in1, got.left_in1);
                check_field("left_in2", want.left_in2, got.left_in2);
                check_field("right_in1", want.right_in1, got.right_in1);
                check_field("right_in2", want.right_in2, got.right_in2);
                check_field("standby_pin", want.standby_pin, got.standby_pin);
                check_field("left_compare", want.left_compare, got.left_compare);
                check_field("right_compare", want.right_compare, got.right_compare);
                check_field("left_applied", int'($signed(want.left_applied)),
                            int'($signed(got.left_applied)));
                check_field("right_applied", int'($signed(want.right_applied)),
                            int'($signed(got.right_applied)));
                check_field("driver_on", want.driver_on, got.driver_on);
            end
        end
    end

    // watchdog: cycles in a row with no beat moving on any port
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // result-side backpressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold_req) begin
                ready_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        logic [2:0]  op;
        logic        ch;
        logic [16:0] cmd;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        errors         = 0;
        idle_on        = 1'b0;
        ready_hold_req = 1'b0;
        stall_cycles   = 0;
        restore_defaults();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].is_wr) begin
                drain();
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].wval);
            end else begin
                send_cmd(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].cmd,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            setup_phase(ph);
            // long receiver stall while commands keep coming: fills the pipe
            if (ph == 1) ready_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0)
                    idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                rand_cmd(op, ch, cmd);
                send_cmd(op, ch, cmd, 1'b0, '0);
            end
        end
        drain();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
